// ===== design/incremental_pid_clamped_core_defines.svh =====
// Assertion macros shared by the incremental PID core RTL.
// Used by files that include this header; relies on clk and arst_n in scope.
`ifndef INCREMENTAL_PID_CLAMPED_CORE_DEFINES_SVH
`define INCREMENTAL_PID_CLAMPED_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define IPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define IPC_ASSERT_NEXT(label, trig, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (conseq)) \
		else $error(msg);

`endif

// ===== design/ipc_pkg.sv =====
// Package for the incremental PID core: field widths, register codes,
// reset values and the configuration / result bundles. No dependencies.
package ipc_pkg;

	localparam int SAMPLE_BITS_DEF    = 12;
	localparam int GAIN_FRAC_BITS_DEF = 24;

	localparam int GAIN_W     = 32;
	localparam int TARGET_W   = 12;
	localparam int DRIVE_W    = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP  = 3'd0,
		REG_GAIN_INTEG = 3'd1,
		REG_GAIN_DERIV = 3'd2,
		REG_TARGET     = 3'd3,
		REG_CEILING    = 3'd4,
		REG_FLOOR      = 3'd5
	} cfg_reg_t;

	localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = 32'sd3355;
	localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = 32'sd839;
	localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = 32'sd0;
	localparam logic [TARGET_W-1:0]      TARGET_RST     = 12'd2800;
	localparam logic [DRIVE_W-1:0]       CEILING_RST    = 16'd1550;
	localparam logic [DRIVE_W-1:0]       FLOOR_RST      = 16'd1450;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_prop;
		logic signed [GAIN_W-1:0] gain_integ;
		logic signed [GAIN_W-1:0] gain_deriv;
		logic [TARGET_W-1:0]      target_lvl;
		logic [DRIVE_W-1:0]       ceil_lvl;
		logic [DRIVE_W-1:0]       floor_lvl;
	} cfg_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic               clamped;
	} res_t;

endpackage

// ===== design/ipc_cfg_regs.sv =====
// Configuration register bank for the incremental PID core.
// Depends on ipc_pkg for register codes, widths and reset values.
module ipc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wen,
	input  logic [ipc_pkg::CFG_IDX_W-1:0]  idx,
	input  logic [ipc_pkg::CFG_DATA_W-1:0] wdata,
	output ipc_pkg::cfg_t                  cfg
);
	import ipc_pkg::*;

	cfg_t cfg_q;

	// Decode the index and update one register; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop  <= GAIN_PROP_RST;
			cfg_q.gain_integ <= GAIN_INTEG_RST;
			cfg_q.gain_deriv <= GAIN_DERIV_RST;
			cfg_q.target_lvl <= TARGET_RST;
			cfg_q.ceil_lvl   <= CEILING_RST;
			cfg_q.floor_lvl  <= FLOOR_RST;
		end else if (wen) begin
			unique case (cfg_reg_t'(idx))
				REG_GAIN_PROP:  cfg_q.gain_prop  <= $signed(wdata[GAIN_W-1:0]);
				REG_GAIN_INTEG: cfg_q.gain_integ <= $signed(wdata[GAIN_W-1:0]);
				REG_GAIN_DERIV: cfg_q.gain_deriv <= $signed(wdata[GAIN_W-1:0]);
				REG_TARGET:     cfg_q.target_lvl <= wdata[TARGET_W-1:0];
				REG_CEILING:    cfg_q.ceil_lvl   <= wdata[DRIVE_W-1:0];
				REG_FLOOR:      cfg_q.floor_lvl  <= wdata[DRIVE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/ipc_datapath.sv =====
// Error history, increment, accumulate and clamp for the incremental PID core.
// Depends on ipc_pkg for the configuration and result bundles.
module ipc_datapath #(
	parameter int SAMPLE_BITS    = ipc_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = ipc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  ipc_pkg::cfg_t          cfg,
	output ipc_pkg::res_t          res
);
	import ipc_pkg::*;

	localparam int ERR_W  = SAMPLE_BITS + 1;
	localparam int DIFF_W = SAMPLE_BITS + 3;
	localparam int PROD_W = GAIN_W + DIFF_W;
	localparam int INC_W  = PROD_W + 2;
	localparam int ACC_W  = DRIVE_W + GAIN_FRAC_BITS;
	localparam int SUM_W  = ((INC_W > ACC_W + 1) ? INC_W : ACC_W + 1) + 1;

	logic [ACC_W-1:0]        acc_q;
	logic signed [ERR_W-1:0] err1_q;
	logic signed [ERR_W-1:0] err2_q;

	logic [TARGET_W+SAMPLE_BITS-1:0] tgt_wide;
	logic signed [ERR_W-1:0]         err;
	logic signed [DIFF_W-1:0]        d_prop, d_integ, d_deriv;
	logic signed [PROD_W-1:0]        p_prop, p_integ, p_deriv;
	logic signed [INC_W-1:0]         inc;
	logic signed [SUM_W-1:0]         sum, hi, lo, lim_sum;
	logic                            lim;

	// Fit the setpoint to the sample width and form the error
	assign tgt_wide = {{SAMPLE_BITS{1'b0}}, cfg.target_lvl};
	assign err = $signed({1'b0, tgt_wide[SAMPLE_BITS-1:0]}) - $signed({1'b0, sample});

	// First difference, sum and second difference of the error history
	assign d_prop  = DIFF_W'(err) - DIFF_W'(err1_q);
	assign d_integ = DIFF_W'(err) + DIFF_W'(err1_q);
	assign d_deriv = DIFF_W'(err) - (DIFF_W'(err1_q) <<< 1) + DIFF_W'(err2_q);

	// Three exact products, gain Q8.F times integer difference
	assign p_prop  = PROD_W'(cfg.gain_prop)  * PROD_W'(d_prop);
	assign p_integ = PROD_W'(cfg.gain_integ) * PROD_W'(d_integ);
	assign p_deriv = PROD_W'(cfg.gain_deriv) * PROD_W'(d_deriv);

	assign inc = INC_W'(p_prop) + INC_W'(p_integ) + INC_W'(p_deriv);
	assign sum = SUM_W'(inc) + $signed({{(SUM_W-ACC_W){1'b0}}, acc_q});

	// Limits as fixed-point values
	assign hi = $signed({{(SUM_W-ACC_W){1'b0}}, cfg.ceil_lvl, {GAIN_FRAC_BITS{1'b0}}});
	assign lo = $signed({{(SUM_W-ACC_W){1'b0}}, cfg.floor_lvl, {GAIN_FRAC_BITS{1'b0}}});

	// Clamp: ceiling first, then floor; an exact hit is not a clamp
	always_comb begin
		lim_sum = sum;
		lim     = 1'b0;
		if (sum > hi) begin
			lim_sum = hi;
			lim     = 1'b1;
		end else if (sum < lo) begin
			lim_sum = lo;
			lim     = 1'b1;
		end
	end

	// Store the clamped accumulator and shift the error history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			err1_q <= '0;
			err2_q <= '0;
		end else if (step) begin
			acc_q  <= lim_sum[ACC_W-1:0];
			err1_q <= err;
			err2_q <= err1_q;
		end
	end

	assign res.drive   = lim_sum[ACC_W-1:GAIN_FRAC_BITS];
	assign res.clamped = lim;

endmodule

// ===== design/incremental_pid_clamped_core.sv =====
// Top level of the incremental PID core: request handshake, input and result
// registers. Depends on ipc_pkg, ipc_cfg_regs, ipc_datapath and the defines header.
//
//  Channel  | Signals                          | Handshake
//  ---------+----------------------------------+-------------------------
//  config   | cfg_wen, cfg_idx, cfg_wdata      | write on cfg_wen, no wait
//  input    | sample                           | in_valid / in_ready
//  result   | drive, clamped                   | out_valid / out_ready
//
// One request per cycle sustained while out_ready holds high; a taken request is
// held in the input register, and its result then goes to the result register.
// The per-cycle path is the accumulator loop: three gain multipliers, the
// increment adder and the clamp compare, all between the input and result registers.
// Reset clears the accumulator and error history and loads the default gains/limits.
// A stalled result holds the result register and any request in the input register;
// input is still taken while the result register is being drained.
`include "incremental_pid_clamped_core_defines.svh"

module incremental_pid_clamped_core #(
	parameter int SAMPLE_BITS    = ipc_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = ipc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [ipc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ipc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [SAMPLE_BITS-1:0]         sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ipc_pkg::DRIVE_W-1:0]    drive,
	output logic                           clamped
);
	import ipc_pkg::*;

	cfg_t cfg;
	res_t res;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   out_valid_q;
	logic [DRIVE_W-1:0]     drive_q;
	logic                   clamped_q;
	logic                   advance;
	logic                   step;

	ipc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.idx    (cfg_idx),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	ipc_datapath #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Advance when the result register is empty or being drained
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register: load a new request or drop the one that moved on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			drive_q   <= res.drive;
			clamped_q <= res.clamped;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;

	// An empty input register never blocks a request
	`IPC_ASSERT(a_ready_when_empty, !valid_s1 |-> in_ready, "in_ready low with empty input stage")
	// A request that moves on lands in the result register
	`IPC_ASSERT_NEXT(a_step_fills_out, step, out_valid_q, "result lost after step")
	// A blocked input stage keeps its request
	`IPC_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(sample_s1),
		"input stage changed while blocked")

endmodule
